/* hdl/gzhp_pkg.sv */
// gzhp_pkg: types, constants and a helper function for the gzip header parser
// no dependencies; used by gzip_header_parser
`timescale 1ns / 1ps
`default_nettype none

package gzhp_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 20;
    localparam int LEN_WIDTH           = 20;
    localparam int SKIP_WIDTH          = 16;
    localparam int FLAG_WIDTH          = 5;

    localparam logic [7:0] MAGIC1       = 8'h1f;
    localparam logic [7:0] MAGIC2       = 8'h8b;
    localparam logic [7:0] METHOD_DEFL  = 8'h08;
    localparam logic [7:0] FLG_RESERVED = 8'he0;

    localparam logic [FLAG_WIDTH-1:0] FLG_CRC     = 5'h02;
    localparam logic [FLAG_WIDTH-1:0] FLG_EXTRA   = 5'h04;
    localparam logic [FLAG_WIDTH-1:0] FLG_NAME    = 5'h08;
    localparam logic [FLAG_WIDTH-1:0] FLG_COMMENT = 5'h10;

    localparam logic [SKIP_WIDTH-1:0] FIXED_SKIP = 16'd6;

    localparam logic [LEN_WIDTH-1:0] LEN_MAX = 20'hfffff;

    typedef enum logic [3:0] {
        PH_MAGIC1  = 4'd0,
        PH_MAGIC2  = 4'd1,
        PH_METHOD  = 4'd2,
        PH_FLAGS   = 4'd3,
        PH_SKIP    = 4'd4,
        PH_XLO     = 4'd5,
        PH_XHI     = 4'd6,
        PH_XDATA   = 4'd7,
        PH_NAME    = 4'd8,
        PH_COMMENT = 4'd9,
        PH_CRC1    = 4'd10,
        PH_CRC2    = 4'd11,
        PH_DONE    = 4'd12
    } phase_t;

    // where the optional sections resume from
    typedef enum logic [1:0] {
        LVL_EXTRA   = 2'd0,
        LVL_NAME    = 2'd1,
        LVL_COMMENT = 2'd2,
        LVL_CRC     = 2'd3
    } level_t;

    // next optional section at or after the given level
    function automatic phase_t pick_section(input logic [FLAG_WIDTH-1:0] flags,
                                            input level_t level);
        phase_t ph;
        ph = PH_DONE;
        if (level <= LVL_EXTRA && (flags & FLG_EXTRA) != '0)
            ph = PH_XLO;
        else if (level <= LVL_NAME && (flags & FLG_NAME) != '0)
            ph = PH_NAME;
        else if (level <= LVL_COMMENT && (flags & FLG_COMMENT) != '0)
            ph = PH_COMMENT;
        else if ((flags & FLG_CRC) != '0)
            ph = PH_CRC1;
        return ph;
    endfunction

endpackage

`default_nettype wire

/* hdl/gzip_header_parser.sv */
// gzip header parser: byte-wide check of a gzip member header, one result per buffer
// results are registered; while the output stalls, a second result stage holds one
// throughput: one byte per cycle unless that second stage is full, then input stalls
// reset: rst_n asynchronous active low; returns the parser to the first magic byte
// depends on gzhp_pkg
`timescale 1ns / 1ps
`default_nettype none

module gzip_header_parser #(
    parameter int COUNT_WIDTH = gzhp_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire  [7:0]                      data_byte,
    input  wire                             last_byte,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic                            status,
    output logic [gzhp_pkg::LEN_WIDTH-1:0]  header_length
);

    localparam int EXT_WIDTH = 33;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    gzhp_pkg::phase_t                    phase_reg, phase_next, phase_step;
    logic [COUNT_WIDTH-1:0]              count_reg, count_next, count_step;
    logic [gzhp_pkg::FLAG_WIDTH-1:0]     flags_reg, flags_next, flags_step;
    logic [gzhp_pkg::SKIP_WIDTH-1:0]     skip_reg, skip_next, skip_step;
    logic                                reported_reg, reported_next, reported_step;

    logic                                out_valid_reg, out_valid_next;
    logic                                out_status_reg, out_status_next;
    logic [gzhp_pkg::LEN_WIDTH-1:0]      out_len_reg, out_len_next;
    logic                                skid_valid_reg, skid_valid_next;
    logic                                skid_status_reg, skid_status_next;
    logic [gzhp_pkg::LEN_WIDTH-1:0]      skid_len_reg, skid_len_next;

    logic                                accept;
    logic                                pop;
    logic                                fail;
    logic                                emit;
    logic                                res_status;
    logic [gzhp_pkg::LEN_WIDTH-1:0]      res_len;
    logic [gzhp_pkg::LEN_WIDTH-1:0]      sat_len;
    logic [EXT_WIDTH-1:0]                count_ext;
    logic                                end_ok;

    assign in_ready      = !skid_valid_reg;
    assign accept        = in_valid && in_ready;
    assign pop           = out_valid_reg && out_ready;
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign header_length = out_len_reg;

    // header parsing for one byte
    always_comb
    begin
        phase_step    = phase_reg;
        count_step    = count_reg;
        flags_step    = flags_reg;
        skip_step     = skip_reg;
        reported_step = reported_reg;
        fail          = 1'b0;
        if (!reported_reg)
        begin
            if (count_reg != COUNT_MAX)
                count_step = count_reg + 1'b1;
            unique case (phase_reg)
                gzhp_pkg::PH_MAGIC1:
                    if (data_byte != gzhp_pkg::MAGIC1) fail = 1'b1;
                    else phase_step = gzhp_pkg::PH_MAGIC2;
                gzhp_pkg::PH_MAGIC2:
                    if (data_byte != gzhp_pkg::MAGIC2) fail = 1'b1;
                    else phase_step = gzhp_pkg::PH_METHOD;
                gzhp_pkg::PH_METHOD:
                    if (data_byte != gzhp_pkg::METHOD_DEFL) fail = 1'b1;
                    else phase_step = gzhp_pkg::PH_FLAGS;
                gzhp_pkg::PH_FLAGS:
                    if ((data_byte & gzhp_pkg::FLG_RESERVED) != '0)
                        fail = 1'b1;
                    else
                    begin
                        flags_step = data_byte[gzhp_pkg::FLAG_WIDTH-1:0];
                        skip_step  = gzhp_pkg::FIXED_SKIP;
                        phase_step = gzhp_pkg::PH_SKIP;
                    end
                gzhp_pkg::PH_SKIP:
                begin
                    skip_step = skip_reg - 1'b1;
                    if (skip_step == '0)
                        phase_step = gzhp_pkg::pick_section(flags_reg, gzhp_pkg::LVL_EXTRA);
                end
                gzhp_pkg::PH_XLO:
                begin
                    skip_step  = {8'h00, data_byte};
                    phase_step = gzhp_pkg::PH_XHI;
                end
                gzhp_pkg::PH_XHI:
                begin
                    skip_step = {data_byte, skip_reg[7:0]};
                    if (skip_step != '0)
                        phase_step = gzhp_pkg::PH_XDATA;
                    else
                        phase_step = gzhp_pkg::pick_section(flags_reg, gzhp_pkg::LVL_NAME);
                end
                gzhp_pkg::PH_XDATA:
                begin
                    skip_step = skip_reg - 1'b1;
                    if (skip_step == '0)
                        phase_step = gzhp_pkg::pick_section(flags_reg, gzhp_pkg::LVL_NAME);
                end
                gzhp_pkg::PH_NAME:
                    if (data_byte == 8'h00)
                        phase_step = gzhp_pkg::pick_section(flags_reg, gzhp_pkg::LVL_COMMENT);
                gzhp_pkg::PH_COMMENT:
                    if (data_byte == 8'h00)
                        phase_step = gzhp_pkg::pick_section(flags_reg, gzhp_pkg::LVL_CRC);
                gzhp_pkg::PH_CRC1:
                    phase_step = gzhp_pkg::PH_CRC2;
                gzhp_pkg::PH_CRC2:
                    phase_step = gzhp_pkg::PH_DONE;
                default:
                    fail = 1'b1;
            endcase
            if (fail)
                phase_step = gzhp_pkg::PH_DONE;
        end

        // length as seen after this byte, clipped to the output width
        count_ext = {{(EXT_WIDTH-COUNT_WIDTH){1'b0}}, count_step};
        if (count_ext > {{(EXT_WIDTH-gzhp_pkg::LEN_WIDTH){1'b0}}, gzhp_pkg::LEN_MAX})
            sat_len = gzhp_pkg::LEN_MAX;
        else
            sat_len = count_ext[gzhp_pkg::LEN_WIDTH-1:0];

        // a cut-short name or comment still passes unless a header crc is due
        end_ok = (phase_step == gzhp_pkg::PH_NAME || phase_step == gzhp_pkg::PH_COMMENT)
                 && ((flags_step & gzhp_pkg::FLG_CRC) == '0);

        emit       = 1'b0;
        res_status = 1'b1;
        if (!reported_reg && (fail || phase_step == gzhp_pkg::PH_DONE))
        begin
            emit          = 1'b1;
            res_status    = fail;
            reported_step = 1'b1;
        end
        else if (last_byte && !reported_reg)
        begin
            emit       = 1'b1;
            res_status = !end_ok;
        end
        res_len = res_status ? '0 : sat_len;
    end

    // state update and result staging
    always_comb
    begin
        phase_next       = phase_reg;
        count_next       = count_reg;
        flags_next       = flags_reg;
        skip_next        = skip_reg;
        reported_next    = reported_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_len_next     = out_len_reg;
        skid_valid_next  = skid_valid_reg;
        skid_status_next = skid_status_reg;
        skid_len_next    = skid_len_reg;

        if (accept)
        begin
            if (last_byte)
            begin
                // buffer end: start over for the next transaction
                phase_next    = gzhp_pkg::PH_MAGIC1;
                count_next    = '0;
                flags_next    = '0;
                skip_next     = '0;
                reported_next = 1'b0;
            end
            else
            begin
                phase_next    = phase_step;
                count_next    = count_step;
                flags_next    = flags_step;
                skip_next     = skip_step;
                reported_next = reported_step;
            end
        end

        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_status_next = skid_status_reg;
                out_len_next    = skid_len_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept && emit)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next  = 1'b1;
                out_status_next = res_status;
                out_len_next    = res_len;
            end
            else
            begin
                skid_valid_next  = 1'b1;
                skid_status_next = res_status;
                skid_len_next    = res_len;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= gzhp_pkg::PH_MAGIC1;
            count_reg      <= '0;
            flags_reg      <= '0;
            skip_reg       <= '0;
            reported_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            flags_reg      <= flags_next;
            skip_reg       <= skip_next;
            reported_reg   <= reported_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg  <= out_status_next;
        out_len_reg     <= out_len_next;
        skid_status_reg <= skid_status_next;
        skid_len_reg    <= skid_len_next;
    end

endmodule

`default_nettype wire
